@@ hw/rtl/register_machine_execute_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the register machine execute block
// Concurrent assertion shorthands used by the checker file rme_checker.
// ----------------------------------------------------------------------------
`ifndef REGISTER_MACHINE_EXECUTE_MACROS_SVH
`define REGISTER_MACHINE_EXECUTE_MACROS_SVH

// Clocked check, disabled while reset is low.
`define RME_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("register_machine_execute: port check failed");

// Clocked check that also runs during reset.
`define RME_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("register_machine_execute: reset check failed");

`endif

@@ hw/rtl/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme_pkg
// Types, constants and decode helpers of the register machine execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rme_pkg;

  localparam int NUM_REGS      = 6;
  localparam int REG_IDX_W     = 3;
  localparam int DATA_W        = 64;
  localparam int IMM_W         = 32;
  localparam int HALF_W        = DATA_W / 2;
  localparam int IP_W          = 8;
  localparam int LEN_W         = 9;
  localparam int OP_W          = 4;
  localparam int PROGRAM_DEPTH = 256;
  localparam int IP_RANGE      = 1 << IP_W;
  localparam int Q_DEPTH       = 2;

  localparam logic [REG_IDX_W-1:0] REG_LAST = REG_IDX_W'(NUM_REGS - 1);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IP_REGISTER    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_SETI = 4'd0,
    OP_SETR = 4'd1,
    OP_ADDI = 4'd2,
    OP_ADDR = 4'd3,
    OP_MULR = 4'd4,
    OP_MULI = 4'd5,
    OP_BANR = 4'd6,
    OP_BANI = 4'd7,
    OP_BORR = 4'd8,
    OP_BORI = 4'd9,
    OP_EQRR = 4'd10,
    OP_EQRI = 4'd11,
    OP_EQIR = 4'd12,
    OP_GTRR = 4'd13,
    OP_GTIR = 4'd14,
    OP_GTRI = 4'd15
  } op_t;

  // Decoded request as it sits in the queue between front and back.
  typedef struct packed {
    op_t                  op;
    logic [IMM_W-1:0]     imm_a;
    logic [IMM_W-1:0]     imm_b;
    logic [REG_IDX_W-1:0] ra;
    logic [REG_IDX_W-1:0] rb;
    logic [REG_IDX_W-1:0] dst;
    logic                 use_a;
    logic                 use_b;
    logic                 bad;
  } dec_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] ip_register;
    logic [LEN_W-1:0]     program_length;
    logic                 ip_written;
  } cfg_t;

  // Bit 0: operand a names a register, bit 1: operand b names a register.
  function automatic logic [1:0] reg_use(op_t op);
    logic [1:0] u;
    unique case (op)
      OP_SETI:                   u = 2'b00;
      OP_SETR, OP_ADDI, OP_MULI,
      OP_BANI, OP_BORI, OP_EQRI,
      OP_GTRI:                   u = 2'b01;
      OP_EQIR, OP_GTIR:          u = 2'b10;
      OP_ADDR, OP_MULR, OP_BANR,
      OP_BORR, OP_EQRR, OP_GTRR: u = 2'b11;
    endcase
    return u;
  endfunction

  function automatic logic [DATA_W-1:0] sext_imm(logic [IMM_W-1:0] imm);
    return {{(DATA_W - IMM_W){imm[IMM_W-1]}}, imm};
  endfunction

endpackage

@@ hw/rtl/rme_ram.sv @@
// ----------------------------------------------------------------------------
// rme_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 6,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  output logic [WIDTH-1:0]  rd_data_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

@@ hw/rtl/rme_front.sv @@
// ----------------------------------------------------------------------------
// rme_front
// Classifies an incoming instruction: register use, index check, queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_front (
  input  logic [rme_pkg::OP_W-1:0]         in_operation,
  input  logic signed [rme_pkg::IMM_W-1:0] in_operand_a,
  input  logic signed [rme_pkg::IMM_W-1:0] in_operand_b,
  input  logic [rme_pkg::REG_IDX_W-1:0]    in_dest_index,
  output rme_pkg::dec_t                    dec_o
);

  rme_pkg::op_t                 op;
  logic [1:0]                   use_bits;
  logic [rme_pkg::IMM_W-1:0]    ua;
  logic [rme_pkg::IMM_W-1:0]    ub;
  logic                         bad_a;
  logic                         bad_b;
  logic                         bad_d;
  logic                         bad;

  always_comb begin
    op       = rme_pkg::op_t'(in_operation);
    use_bits = rme_pkg::reg_use(op);
    ua       = in_operand_a;
    ub       = in_operand_b;
    // Negative indexes read as huge unsigned values and fail here too.
    bad_a    = use_bits[0] && (ua > rme_pkg::IMM_W'(rme_pkg::REG_LAST));
    bad_b    = use_bits[1] && (ub > rme_pkg::IMM_W'(rme_pkg::REG_LAST));
    bad_d    = in_dest_index > rme_pkg::REG_LAST;
    bad      = bad_a || bad_b || bad_d;

    dec_o.op    = op;
    dec_o.imm_a = ua;
    dec_o.imm_b = ub;
    // Park unused or bad indexes at zero so the file is never read out of range.
    dec_o.ra    = (use_bits[0] && !bad) ? ua[rme_pkg::REG_IDX_W-1:0] : '0;
    dec_o.rb    = (use_bits[1] && !bad) ? ub[rme_pkg::REG_IDX_W-1:0] : '0;
    dec_o.dst   = bad ? '0 : in_dest_index;
    dec_o.use_a = use_bits[0];
    dec_o.use_b = use_bits[1];
    dec_o.bad   = bad;
  end

endmodule

@@ hw/rtl/rme_queue.sv @@
// ----------------------------------------------------------------------------
// rme_queue
// Short FIFO of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  rme_pkg::dec_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output rme_pkg::dec_t pop_data
);

  localparam int PTR_W = (rme_pkg::Q_DEPTH > 1) ? $clog2(rme_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(rme_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(rme_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(rme_pkg::Q_DEPTH);

  rme_pkg::dec_t    entry_r [rme_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  always_comb begin
    push_ready = count_r != CNT_FULL;
    pop_valid  = count_r != '0;
    pop_data   = entry_r[rd_ptr_r];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/rme_back.sv @@
// ----------------------------------------------------------------------------
// rme_back
// Execute unit: register file, ALU, split multiplier, pointer and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_back #(
  parameter int PROGRAM_DEPTH = rme_pkg::PROGRAM_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rme_pkg::cfg_t                       cfg,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  rme_pkg::dec_t                       q_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rme_pkg::IP_W-1:0]            out_next_ip,
  output logic signed [rme_pkg::DATA_W-1:0]   out_written_value,
  output logic                                out_halted,
  output logic                                out_bad_index
);

  localparam int DW  = rme_pkg::DATA_W;
  localparam int HW  = rme_pkg::HALF_W;
  localparam int IW  = rme_pkg::REG_IDX_W;

  // Effective length cap: program depth, and never past the pointer range.
  localparam logic [rme_pkg::LEN_W-1:0] LEN_CAP =
    rme_pkg::LEN_W'((PROGRAM_DEPTH < rme_pkg::IP_RANGE) ? PROGRAM_DEPTH
                                                        : rme_pkg::IP_RANGE);

  // Execute slot
  logic                 x_valid_r, x_valid_nxt;
  rme_pkg::dec_t        x_r;
  logic                 x_phase_r, x_phase_nxt;
  logic [DW-1:0]        p_ll_r;
  logic [HW-1:0]        p_lh_r;
  logic [HW-1:0]        p_hl_r;

  // Architectural state
  logic [rme_pkg::IP_W-1:0]     ip_ptr_r;
  logic [rme_pkg::NUM_REGS-1:0] vld_r;

  // Write bypass covers the read that was registered at the same edge as a write.
  logic                 byp_valid_r;
  logic [IW-1:0]        byp_idx_r;
  logic [DW-1:0]        byp_data_r;

  // Pending pointer copy into the bound register, written back on rebind.
  logic                 ov_valid_r;
  logic [IW-1:0]        ov_idx_r;
  logic [rme_pkg::IP_W-1:0] ov_val_r;
  logic                 flush_r;

  logic                 out_valid_r;
  logic [rme_pkg::IP_W-1:0] out_ip_r;
  logic [DW-1:0]        out_val_r;
  logic                 out_halt_r;
  logic                 out_bad_r;

  logic [DW-1:0]        rd_data_a;
  logic [DW-1:0]        rd_data_b;
  logic [IW-1:0]        rd_addr_a;
  logic [IW-1:0]        rd_addr_b;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [DW-1:0]        wr_data;

  logic                 bound;
  logic [DW-1:0]        ra_val;
  logic [DW-1:0]        rb_val;
  logic [DW-1:0]        va;
  logic [DW-1:0]        vb;
  logic                 is_mul;
  logic                 need_mul_step;
  logic [DW-1:0]        mul_sum;
  logic [DW-1:0]        alu_res;
  logic [DW-1:0]        result;
  logic                 out_free;
  logic                 x_done;
  logic                 x_load;
  logic [DW-1:0]        np_base;
  logic [DW-1:0]        np;
  logic [rme_pkg::LEN_W-1:0] len_eff;
  logic                 halted;

  function automatic logic [DW-1:0] read_reg(
    input logic [IW-1:0]               idx,
    input logic [DW-1:0]               ram_val,
    input logic                        bnd,
    input logic [IW-1:0]               ip_idx,
    input logic [rme_pkg::IP_W-1:0]    ptr,
    input logic                        bv,
    input logic [IW-1:0]               bidx,
    input logic [DW-1:0]               bdata,
    input logic [rme_pkg::NUM_REGS-1:0] vld
  );
    logic [DW-1:0] v;
    priority if (bnd && idx == ip_idx) begin
      v = {{(DW - rme_pkg::IP_W){1'b0}}, ptr};
    end else if (bv && idx == bidx) begin
      v = bdata;
    end else if (vld[idx]) begin
      v = ram_val;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  rme_ram #(
    .WIDTH (DW),
    .DEPTH (rme_pkg::NUM_REGS)
  ) u_regfile (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  always_comb begin
    bound  = cfg.ip_register <= rme_pkg::REG_LAST;
    ra_val = read_reg(x_r.ra, rd_data_a, bound, cfg.ip_register, ip_ptr_r,
                      byp_valid_r, byp_idx_r, byp_data_r, vld_r);
    rb_val = read_reg(x_r.rb, rd_data_b, bound, cfg.ip_register, ip_ptr_r,
                      byp_valid_r, byp_idx_r, byp_data_r, vld_r);
    va     = x_r.use_a ? ra_val : rme_pkg::sext_imm(x_r.imm_a);
    vb     = x_r.use_b ? rb_val : rme_pkg::sext_imm(x_r.imm_b);

    is_mul        = (x_r.op == rme_pkg::OP_MULR) || (x_r.op == rme_pkg::OP_MULI);
    need_mul_step = is_mul && !x_r.bad && !x_phase_r;
    mul_sum       = p_ll_r + {p_lh_r + p_hl_r, {HW{1'b0}}};

    unique case (x_r.op)
      rme_pkg::OP_SETI:                   alu_res = rme_pkg::sext_imm(x_r.imm_a);
      rme_pkg::OP_SETR:                   alu_res = va;
      rme_pkg::OP_ADDI, rme_pkg::OP_ADDR: alu_res = va + vb;
      rme_pkg::OP_MULR, rme_pkg::OP_MULI: alu_res = mul_sum;
      rme_pkg::OP_BANR, rme_pkg::OP_BANI: alu_res = va & vb;
      rme_pkg::OP_BORR, rme_pkg::OP_BORI: alu_res = va | vb;
      rme_pkg::OP_EQRR, rme_pkg::OP_EQRI,
      rme_pkg::OP_EQIR: alu_res = {{(DW - 1){1'b0}}, va == vb};
      rme_pkg::OP_GTRR, rme_pkg::OP_GTIR,
      rme_pkg::OP_GTRI: alu_res = {{(DW - 1){1'b0}}, $signed(va) > $signed(vb)};
    endcase
    result = x_r.bad ? '0 : alu_res;

    out_free = !out_valid_r || out_ready;
    x_done   = x_valid_r && !need_mul_step && out_free;
    x_load   = q_valid && (!x_valid_r || x_done) && !flush_r;
    q_ready  = x_load;

    // Keep reading the slot's own operands while it holds.
    rd_addr_a = (x_valid_r && !x_done) ? x_r.ra : q_data.ra;
    rd_addr_b = (x_valid_r && !x_done) ? x_r.rb : q_data.rb;

    wr_en   = 1'b0;
    wr_addr = x_r.dst;
    wr_data = result;
    priority if (x_done && !x_r.bad) begin
      wr_en = 1'b1;
    end else if (flush_r && ov_valid_r) begin
      wr_en   = 1'b1;
      wr_addr = ov_idx_r;
      wr_data = {{(DW - rme_pkg::IP_W){1'b0}}, ov_val_r};
    end else begin
      wr_en = 1'b0;
    end

    np_base = (!x_r.bad && bound && x_r.dst == cfg.ip_register) ?
              result : {{(DW - rme_pkg::IP_W){1'b0}}, ip_ptr_r};
    np      = np_base + DW'(1);
    len_eff = (cfg.program_length > LEN_CAP) ? LEN_CAP : cfg.program_length;
    halted  = np >= {{(DW - rme_pkg::LEN_W){1'b0}}, len_eff};

    x_valid_nxt = x_valid_r;
    if (x_load) begin
      x_valid_nxt = 1'b1;
    end else if (x_done) begin
      x_valid_nxt = 1'b0;
    end
    x_phase_nxt = x_phase_r;
    if (x_load) begin
      x_phase_nxt = 1'b0;
    end else if (x_valid_r && need_mul_step) begin
      x_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      x_phase_r   <= 1'b0;
      ip_ptr_r    <= '0;
      vld_r       <= '0;
      byp_valid_r <= 1'b0;
      ov_valid_r  <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_valid_r   <= x_valid_nxt;
      x_phase_r   <= x_phase_nxt;
      byp_valid_r <= wr_en;
      flush_r     <= cfg.ip_written;
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (flush_r) begin
        ov_valid_r <= 1'b0;
      end
      if (x_done) begin
        ip_ptr_r <= np[rme_pkg::IP_W-1:0];
        if (!x_r.bad && bound) begin
          // Destination equal to the bound register overwrites the copy.
          ov_valid_r <= x_r.dst != cfg.ip_register;
        end
      end
      if (x_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (x_load) begin
      x_r <= q_data;
    end
    if (x_valid_r && need_mul_step) begin
      p_ll_r <= va[HW-1:0] * vb[HW-1:0];
      p_lh_r <= va[HW-1:0] * vb[DW-1:HW];
      p_hl_r <= va[DW-1:HW] * vb[HW-1:0];
    end
    byp_idx_r  <= wr_addr;
    byp_data_r <= wr_data;
    if (x_done && !x_r.bad && bound) begin
      ov_idx_r <= cfg.ip_register;
      ov_val_r <= ip_ptr_r;
    end
    if (x_done) begin
      out_ip_r   <= halted ? '0 : np[rme_pkg::IP_W-1:0];
      out_val_r  <= result;
      out_halt_r <= halted;
      out_bad_r  <= x_r.bad;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_ip       = out_ip_r;
  assign out_written_value = out_val_r;
  assign out_halted        = out_halt_r;
  assign out_bad_index     = out_bad_r;

endmodule

@@ hw/rtl/register_machine_execute.sv @@
// ----------------------------------------------------------------------------
// register_machine_execute
// Execute stage of a six-register machine with a register-bound pointer.
// ----------------------------------------------------------------------------
// One instruction is accepted per cycle while the queue has room, and each
// gives one result. A classify stage checks register indexes and feeds a
// two-entry queue; the execute unit reads the six-entry register file
// (registered read, write bypass), so results other than multiplies stream at
// one per cycle while the output is taken. Multiply holds the execute slot for
// a second step (three 32x32 partial products, then the sum), so the next
// instruction waits for the sum. Results wait in an output register. The
// register file clears through per-entry valid bits, with no clearing pass.
// After a write of ip_register the execute unit holds off new instructions to store the pending pointer copy.
`timescale 1ns / 1ps

module register_machine_execute #(
  parameter int PROGRAM_DEPTH = rme_pkg::PROGRAM_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rme_pkg::OP_W-1:0]            in_operation,
  input  logic signed [rme_pkg::IMM_W-1:0]    in_operand_a,
  input  logic signed [rme_pkg::IMM_W-1:0]    in_operand_b,
  input  logic [rme_pkg::REG_IDX_W-1:0]       in_dest_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rme_pkg::IP_W-1:0]            out_next_ip,
  output logic signed [rme_pkg::DATA_W-1:0]   out_written_value,
  output logic                                out_halted,
  output logic                                out_bad_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rme_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rme_pkg::LEN_W-1:0]           cfg_data
);

  logic [rme_pkg::REG_IDX_W-1:0] ip_reg_r;
  logic [rme_pkg::LEN_W-1:0]     prog_len_r;
  logic                          cfg_wr;
  rme_pkg::cfg_t                 cfg;
  rme_pkg::dec_t                 dec;
  rme_pkg::dec_t                 q_data;
  logic                          q_valid;
  logic                          q_ready;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_reg_r   <= '0;
      prog_len_r <= rme_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rme_pkg::CFG_IP_REGISTER:
          ip_reg_r <= cfg_data[rme_pkg::REG_IDX_W-1:0];
        rme_pkg::CFG_PROGRAM_LENGTH:
          prog_len_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    cfg.ip_register    = ip_reg_r;
    cfg.program_length = prog_len_r;
    cfg.ip_written     = cfg_wr && (cfg_index == rme_pkg::CFG_IP_REGISTER);
  end

  rme_front u_front (
    .in_operation  (in_operation),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .in_dest_index (in_dest_index),
    .dec_o         (dec)
  );

  rme_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (dec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  rme_back #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_data            (q_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_ip       (out_next_ip),
    .out_written_value (out_written_value),
    .out_halted        (out_halted),
    .out_bad_index     (out_bad_index)
  );

endmodule

@@ hw/rtl/rme_checker.sv @@
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "register_machine_execute_macros.svh"

module rme_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [rme_pkg::IP_W-1:0]          out_next_ip,
  input logic signed [rme_pkg::DATA_W-1:0] out_written_value,
  input logic                              out_halted,
  input logic                              out_bad_index
);

  // A stalled result holds.
  `RME_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_written_value) && $stable(out_next_ip))

  // Halted results carry a zero pointer.
  `RME_ASSERT(a_halt_ip_zero, clk, rst_n, out_valid && out_halted |-> out_next_ip == '0)

  // A rejected index writes nothing, so the shown value is zero.
  `RME_ASSERT(a_bad_value_zero, clk, rst_n, out_valid && out_bad_index |-> out_written_value == '0)

  // Reset drops any pending result.
  `RME_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind register_machine_execute rme_checker u_rme_checker (.*);

@@ test/rme_exec_checker.sv @@
// ----------------------------------------------------------------------------
// rme_exec_checker
// Watches the request, result and configuration channels of the execute
// block, predicts each result from its own copy of the machine state and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rme_exec_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [rme_pkg::OP_W-1:0]          in_operation,
  input  logic [rme_pkg::IMM_W-1:0]         in_operand_a,
  input  logic [rme_pkg::IMM_W-1:0]         in_operand_b,
  input  logic [rme_pkg::REG_IDX_W-1:0]     in_dest_index,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [rme_pkg::IP_W-1:0]          out_next_ip,
  input  logic [rme_pkg::DATA_W-1:0]        out_written_value,
  input  logic                              out_halted,
  input  logic                              out_bad_index,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rme_pkg::LEN_W-1:0]         cfg_data,
  output int                                fail_count,
  output int                                pending_count
);
  import rme_pkg::*;

  typedef struct packed {
    logic [IP_W-1:0]   next_ip;
    logic [DATA_W-1:0] value;
    logic              halted;
    logic              bad_index;
  } exec_result_t;

  logic [DATA_W-1:0]    regs [NUM_REGS];
  logic [IP_W-1:0]      ip_ptr;
  logic [REG_IDX_W-1:0] ip_sel;
  logic [LEN_W-1:0]     prog_len;
  exec_result_t         results_due [$];

  task automatic execute_instr(input logic [OP_W-1:0] op_raw,
                               input logic [IMM_W-1:0] a,
                               input logic [IMM_W-1:0] b,
                               input logic [REG_IDX_W-1:0] dst,
                               output exec_result_t res);
    op_t               op;
    logic              a_reg;
    logic              b_reg;
    logic              bad;
    logic              bound;
    logic [DATA_W-1:0] va;
    logic [DATA_W-1:0] vb;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] np;
    logic [DATA_W-1:0] len;
    op = op_t'(op_raw);
    a_reg = !(op inside {OP_SETI, OP_EQIR, OP_GTIR});
    b_reg = op inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_EQRR, OP_GTRR,
                       OP_EQIR, OP_GTIR};
    // register operands are unsigned here, so negatives count as out of range
    bad = (dst >= NUM_REGS) || (a_reg && a >= NUM_REGS) || (b_reg && b >= NUM_REGS);
    bound = ip_sel < NUM_REGS;
    value = '0;
    if (!bad) begin
      if (bound) regs[ip_sel] = {{(DATA_W - IP_W){1'b0}}, ip_ptr};
      va = a_reg ? regs[a[REG_IDX_W-1:0]] : {{(DATA_W - IMM_W){a[IMM_W-1]}}, a};
      vb = b_reg ? regs[b[REG_IDX_W-1:0]] : {{(DATA_W - IMM_W){b[IMM_W-1]}}, b};
      case (op)
        OP_SETI:                   value = {{(DATA_W - IMM_W){a[IMM_W-1]}}, a};
        OP_SETR:                   value = va;
        OP_ADDI, OP_ADDR:          value = va + vb;
        OP_MULR, OP_MULI:          value = va * vb;
        OP_BANR, OP_BANI:          value = va & vb;
        OP_BORR, OP_BORI:          value = va | vb;
        OP_EQRR, OP_EQRI, OP_EQIR: value = {{(DATA_W - 1){1'b0}}, va == vb};
        default:                   value = {{(DATA_W - 1){1'b0}}, $signed(va) > $signed(vb)};
      endcase
      regs[dst] = value;
    end
    if (!bad && bound) np = regs[ip_sel] + 64'd1;
    else               np = {{(DATA_W - IP_W){1'b0}}, ip_ptr} + 64'd1;
    len = {{(DATA_W - LEN_W){1'b0}}, prog_len};
    if (len > PROGRAM_DEPTH) len = PROGRAM_DEPTH;
    if (len > IP_RANGE) len = IP_RANGE;
    // a wrapped pointer is huge as unsigned, so it halts here too
    res.halted    = np >= len;
    res.next_ip   = res.halted ? '0 : np[IP_W-1:0];
    res.value     = value;
    res.bad_index = bad;
    ip_ptr = np[IP_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    exec_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      ip_ptr = '0;
      ip_sel = '0;
      prog_len = LEN_W'(1);
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IP_REGISTER) ip_sel = cfg_data[REG_IDX_W-1:0];
        else if (cfg_index == CFG_PROGRAM_LENGTH) prog_len = cfg_data;
      end
      // results first: a result never belongs to the request taken this edge
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h %h %b %b", $time,
                   out_next_ip, out_written_value, out_halted, out_bad_index);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          check_field("next_ip", DATA_W'(want.next_ip), DATA_W'(out_next_ip));
          check_field("written_value", want.value, out_written_value);
          check_field("halted", DATA_W'(want.halted), DATA_W'(out_halted));
          check_field("bad_index", DATA_W'(want.bad_index), DATA_W'(out_bad_index));
        end
      end
      if (in_valid && in_ready) begin
        execute_instr(in_operation, in_operand_a, in_operand_b, in_dest_index, want);
        results_due.push_back(want);
      end
    end
    pending_count = results_due.size();
  end

endmodule

@@ test/register_machine_execute_tb.sv @@
// ----------------------------------------------------------------------------
// register_machine_execute_tb
// Drives instructions and configuration writes into the execute block under
// random stalls on both channels; a checker beside the block predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module register_machine_execute_tb;
  import rme_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 48;
  localparam logic [IMM_W-1:0] IMM_MIN = 32'h8000_0000;
  localparam logic [IMM_W-1:0] IMM_MAX = 32'h7fff_ffff;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_operation = '0;
  logic [IMM_W-1:0]     in_operand_a = '0;
  logic [IMM_W-1:0]     in_operand_b = '0;
  logic [REG_IDX_W-1:0] in_dest_index = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IP_W-1:0]      out_next_ip;
  logic [DATA_W-1:0]    out_written_value;
  logic                 out_halted;
  logic                 out_bad_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0]     cfg_data = '0;

  int send_idle_pct = 36;
  int recv_idle_pct = 64;
  int fail_count;
  int pending_count;
  int stall_cycles = 0;

  register_machine_execute DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .in_dest_index     (in_dest_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_ip       (out_next_ip),
    .out_written_value (out_written_value),
    .out_halted        (out_halted),
    .out_bad_index     (out_bad_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  rme_exec_checker u_exec_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .in_dest_index     (in_dest_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_next_ip       (out_next_ip),
    .out_written_value (out_written_value),
    .out_halted        (out_halted),
    .out_bad_index     (out_bad_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic issue_instr(input op_t op, input logic [IMM_W-1:0] a,
                             input logic [IMM_W-1:0] b, input logic [REG_IDX_W-1:0] dst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_operand_a  <= a;
    in_operand_b  <= b;
    in_dest_index <= dst;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain every outstanding request, then leave the block quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [LEN_W-1:0] ip_sel, input logic [LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IP_REGISTER;
    cfg_data  <= ip_sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_PROGRAM_LENGTH;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [IMM_W-1:0] rand_imm();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(0, 40);
      2:       return -$urandom_range(1, 40);
      3:       return IMM_MIN;
      4:       return IMM_MAX;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_random_instr();
    op_t                  op;
    logic [IMM_W-1:0]     a;
    logic [IMM_W-1:0]     b;
    logic [REG_IDX_W-1:0] dst;
    op = op_t'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      // noise: raw operands, mostly out-of-range register indexes
      a = $urandom;
      b = $urandom;
      dst = $urandom_range(0, 7);
    end else begin
      a = (op inside {OP_SETI, OP_EQIR, OP_GTIR}) ? rand_imm() : $urandom_range(0, NUM_REGS - 1);
      b = (op inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_EQRR, OP_GTRR, OP_EQIR, OP_GTIR})
          ? $urandom_range(0, NUM_REGS - 1) : rand_imm();
      dst = $urandom_range(0, NUM_REGS - 1);
    end
    issue_instr(op, a, b, dst);
  endtask

  initial begin : stimulus
    logic [LEN_W-1:0] ip_sel;
    logic [LEN_W-1:0] len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_config(0, 256);

    // every opcode, operand extremes, indexes the opcode never reads
    issue_instr(OP_SETI, IMM_MAX, IMM_MIN, 1);
    issue_instr(OP_SETI, IMM_MIN, -1, 2);
    issue_instr(OP_SETR, 1, 7, 3);
    issue_instr(OP_ADDI, 1, -1, 4);
    issue_instr(OP_ADDR, 1, 2, 5);
    issue_instr(OP_MULR, 5, 5, 4);
    issue_instr(OP_MULI, 2, IMM_MAX, 3);
    issue_instr(OP_BANR, 1, 2, 5);
    issue_instr(OP_BANI, 2, -1, 4);
    issue_instr(OP_BORR, 1, 2, 3);
    issue_instr(OP_BORI, 4, 0, 5);
    issue_instr(OP_EQRR, 3, 3, 1);
    issue_instr(OP_EQRI, 1, 1, 2);
    issue_instr(OP_EQIR, IMM_MIN, 2, 4);
    issue_instr(OP_GTRR, 2, 1, 5);
    issue_instr(OP_GTIR, -1, 2, 3);
    issue_instr(OP_GTRI, 4, IMM_MIN, 0);
    // bad register indexes: operand, negative operand, destination
    issue_instr(OP_ADDR, 1, 6, 2);
    issue_instr(OP_SETR, -1, 0, 1);
    issue_instr(OP_SETI, 5, 0, 6);
    issue_instr(OP_SETI, 5, 0, 7);
    // build the largest positive value in the bound register: pointer wraps
    issue_instr(OP_SETI, IMM_MIN, 0, 1);
    issue_instr(OP_MULR, 1, 1, 2);
    issue_instr(OP_ADDR, 2, 2, 2);
    issue_instr(OP_ADDI, 2, -1, 0);
    issue_instr(OP_ADDI, 0, 0, 1);

    for (int s = 0; s < SEGMENTS; s++) begin
      case (s / 4)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // walk all bindings, unbound ones included, then pick at random
      ip_sel = (s < 8) ? LEN_W'(s) : LEN_W'($urandom_range(0, 7));
      case (s)
        0:       len = 0;
        1:       len = 511;
        2:       len = 257;
        3:       len = 1;
        4:       len = 256;
        5:       len = 255;
        default: len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(2, 40);
      endcase
      wait_idle();
      set_config(ip_sel, len);
      repeat (SEGMENT_ITEMS) issue_random_instr();
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/rme_pkg.sv
hw/rtl/rme_ram.sv
hw/rtl/rme_front.sv
hw/rtl/rme_queue.sv
hw/rtl/rme_back.sv
hw/rtl/register_machine_execute.sv
hw/rtl/rme_checker.sv
test/rme_exec_checker.sv
test/register_machine_execute_tb.sv
